>>> rtl/ght_pkg.sv
`timescale 1ns / 1ps
// Package for the generational handle table: command and status codes,
// token layout, stream packing widths and the controller state type.
// Depends on nothing.
package ght_pkg;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RESOLVE = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_NULL   = 2'd3;

  localparam int KIND_W       = 7;
  localparam int TOKEN_W      = 32;
  localparam int TOK_SLOT_W   = 12;
  localparam int TOK_GEN_W    = 12;
  localparam int TOKEN_OUT_W  = 31;
  localparam int OBJ_PORT_W   = 32;
  localparam int COUNT_W      = 11;
  localparam int REJECT_W     = 32;
  localparam int WORD_BITS    = 32;
  localparam int WORD_BIT_W   = 5;
  localparam int IN_DATA_W    = 80;
  localparam int OUT_DATA_W   = 120;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_PICK = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

endpackage

>>> rtl/ght_first_set.sv
`timescale 1ns / 1ps
// Priority encoder that finds the lowest set bit of a vector.
// Used by the handle table top level for the free-slot search; no dependencies.
module ght_first_set #(
  parameter int WIDTH = 32,
  parameter int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  logic [WIDTH-1:0] vec,
  output logic             found,
  output logic [IDX_W-1:0] index
);

  always_comb begin
    found = |vec;
    index = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        index = IDX_W'(i);
      end
    end
  end

endmodule

>>> rtl/generational_handle_table_top.sv
`timescale 1ns / 1ps
// Generational handle table: allocate, resolve and release of checked tokens.
// Commands are taken only in S_IDLE, one at a time: resolve, release and rejected commands
// pass S_LOOK and S_EXEC for the slot memory read; allocate also passes S_PICK, since the
// free-bitmap word is read before the slot. The result is registered on leaving S_EXEC.
// Reset is synchronous and takes effect at once: a high-water mark and per-word valid
// flags make the slot and bitmap memories read as empty, with no clearing pass.
module generational_handle_table_top #(
  parameter int SLOT_COUNT      = 1024,
  parameter int GENERATION_BITS = 12,
  parameter int OBJECT_BITS     = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // cmd[1:0], object_ref[33:2], kind[40:34], token[72:41], zero pad
  input  logic [ght_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[1:0], token_out[32:2], object_out[64:33], live_count[75:65],
  // rejected_count[107:76], retired_count[118:108], zero pad
  output logic [ght_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WORDS      = (SLOT_COUNT + ght_pkg::WORD_BITS - 1) / ght_pkg::WORD_BITS;
  localparam int WORD_IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PICK_W     = WORD_IDX_W + ght_pkg::WORD_BIT_W;
  localparam int OBJ_W      = (OBJECT_BITS < ght_pkg::OBJ_PORT_W) ? OBJECT_BITS
                                                                  : ght_pkg::OBJ_PORT_W;
  localparam logic [GENERATION_BITS-1:0] GEN_MAX = {GENERATION_BITS{1'b1}};

  typedef struct packed {
    logic                       retired;
    logic [GENERATION_BITS-1:0] gen;
    logic [ght_pkg::KIND_W-1:0] kind;
    logic [OBJ_W-1:0]           obj;
  } slot_t;

  ght_pkg::state_t state;

  logic [1:0]                    cmd_q;
  logic [OBJ_W-1:0]              obj_q;
  logic [ght_pkg::KIND_W-1:0]    kind_q;
  logic [ght_pkg::TOKEN_W-1:0]   token_q;
  logic [WORD_IDX_W-1:0]         widx_q;
  logic                          any_free_q;

  slot_t                         slot_mem [SLOT_COUNT];
  slot_t                         slot_q;
  logic                          slot_live_q;
  logic [SLOT_IDX_W-1:0]         slot_addr_q;
  logic [SLOT_IDX_W:0]           hw;

  logic [ght_pkg::WORD_BITS-1:0] bm_mem [WORDS];
  logic [ght_pkg::WORD_BITS-1:0] bm_q;
  logic                          bm_valid_q;
  logic [WORD_IDX_W-1:0]         bm_addr_q;
  logic [WORDS-1:0]              word_valid;
  logic [WORDS-1:0]              summary;

  logic [ght_pkg::COUNT_W-1:0]   live_total;
  logic [ght_pkg::REJECT_W-1:0]  rejected_total;
  logic [ght_pkg::COUNT_W-1:0]   retired_total;

  logic [1:0]                    status_q;
  logic [ght_pkg::TOKEN_OUT_W-1:0] token_out_q;
  logic [ght_pkg::OBJ_PORT_W-1:0]  object_out_q;

  logic                          any_free;
  logic [WORD_IDX_W-1:0]         free_word;
  logic                          pick_found;
  logic [ght_pkg::WORD_BIT_W-1:0] pick_bit;

  logic [ght_pkg::TOK_SLOT_W-1:0] tok_field;
  logic [ght_pkg::TOK_SLOT_W-1:0] tok_field_m1;
  logic [ght_pkg::TOK_GEN_W-1:0]  tok_gen;
  logic [ght_pkg::KIND_W-1:0]     tok_kind;
  logic                           tok_side;
  logic [SLOT_IDX_W-1:0]          tok_idx;
  logic [PICK_W-1:0]              tok_idx_ext;
  logic [WORD_IDX_W-1:0]          tok_word;
  logic [PICK_W-1:0]              pick_full;
  logic [SLOT_IDX_W-1:0]          pick_idx;
  logic [PICK_W-1:0]              exec_ext;
  logic [ght_pkg::WORD_BIT_W-1:0] exec_bit;
  logic [ght_pkg::WORD_BITS-1:0]  exec_mask;

  logic [ght_pkg::WORD_BITS-1:0] word_init;
  logic [ght_pkg::WORD_BITS-1:0] bm_word;
  logic [ght_pkg::WORD_BITS-1:0] bm_word_next;
  slot_t                         slot_rec;
  slot_t                         slot_wr;

  logic                          slot_rd_en;
  logic [SLOT_IDX_W-1:0]         slot_rd_addr;
  logic                          bm_rd_en;
  logic [WORD_IDX_W-1:0]         bm_rd_addr;

  logic                          pre_ok;
  logic                          check_ok;
  logic                          alloc_go;
  logic                          release_go;
  logic                          retire;
  logic                          reject;
  logic                          exec_fire;
  logic [GENERATION_BITS-1:0]    alloc_gen;
  logic [1:0]                    status_next;
  logic [ght_pkg::TOKEN_OUT_W-1:0] token_out_next;
  logic [ght_pkg::OBJ_PORT_W-1:0]  object_out_next;
  logic [ght_pkg::TOK_SLOT_W-1:0]  slot_plus1;

  ght_first_set #(.WIDTH(WORDS), .IDX_W(WORD_IDX_W)) u_word_search (
    .vec   (summary),
    .found (any_free),
    .index (free_word)
  );

  ght_first_set #(.WIDTH(ght_pkg::WORD_BITS), .IDX_W(ght_pkg::WORD_BIT_W)) u_bit_search (
    .vec   (bm_word),
    .found (pick_found),
    .index (pick_bit)
  );

  assign s_axis_tready = (state == ght_pkg::S_IDLE);
  assign exec_fire     = (state == ght_pkg::S_EXEC) && (!m_axis_tvalid || m_axis_tready);

  assign tok_field    = token_q[ght_pkg::TOK_SLOT_W-1:0];
  assign tok_field_m1 = tok_field - ght_pkg::TOK_SLOT_W'(1);
  assign tok_gen      = token_q[23:12];
  assign tok_kind     = token_q[30:24];
  assign tok_side     = token_q[31];
  assign tok_idx      = tok_field_m1[SLOT_IDX_W-1:0];
  assign tok_idx_ext  = PICK_W'(tok_idx);
  assign tok_word     = tok_idx_ext[PICK_W-1:ght_pkg::WORD_BIT_W];

  assign pick_full    = {bm_addr_q, pick_bit};
  assign pick_idx     = pick_full[SLOT_IDX_W-1:0];
  assign exec_ext     = PICK_W'(slot_addr_q);
  assign exec_bit     = exec_ext[ght_pkg::WORD_BIT_W-1:0];
  assign exec_mask    = ght_pkg::WORD_BITS'(1) << exec_bit;

  always_comb begin
    for (int b = 0; b < ght_pkg::WORD_BITS; b++) begin
      word_init[b] = (int'(bm_addr_q) * ght_pkg::WORD_BITS + b) < SLOT_COUNT;
    end
    bm_word  = bm_valid_q ? bm_q : word_init;
    slot_rec = slot_live_q ? slot_q : '0;
  end

  always_comb begin
    slot_rd_en   = 1'b0;
    slot_rd_addr = tok_idx;
    bm_rd_en     = 1'b0;
    bm_rd_addr   = (cmd_q == ght_pkg::CMD_ALLOC) ? widx_q : tok_word;
    unique case (state)
      ght_pkg::S_LOOK: begin
        slot_rd_en = 1'b1;
        bm_rd_en   = 1'b1;
      end
      ght_pkg::S_PICK: begin
        slot_rd_en   = 1'b1;
        slot_rd_addr = pick_idx;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pre_ok = !tok_side && (tok_kind == kind_q) && (tok_field != '0) &&
             ({1'b0, tok_field} <= (ght_pkg::TOK_SLOT_W + 1)'(SLOT_COUNT)) &&
             (tok_gen != '0);
    check_ok = pre_ok && (slot_rec.obj != '0) && !slot_rec.retired &&
               (slot_rec.kind == kind_q) &&
               (ght_pkg::TOK_GEN_W'(slot_rec.gen) == tok_gen);
    alloc_go   = (cmd_q == ght_pkg::CMD_ALLOC) && (obj_q != '0) && any_free_q && pick_found;
    release_go = (cmd_q == ght_pkg::CMD_RELEASE) && check_ok;
    reject     = ((cmd_q == ght_pkg::CMD_RESOLVE) || (cmd_q == ght_pkg::CMD_RELEASE)) &&
                 !check_ok;
    retire     = (slot_rec.gen >= GEN_MAX);
    alloc_gen  = (slot_rec.gen == '0) ? GENERATION_BITS'(1) : slot_rec.gen;
    slot_plus1 = ght_pkg::TOK_SLOT_W'(slot_addr_q) + ght_pkg::TOK_SLOT_W'(1);

    case (cmd_q)
      ght_pkg::CMD_ALLOC: begin
        if (obj_q == '0) begin
          status_next = ght_pkg::ST_NULL;
        end else if (!any_free_q || !pick_found) begin
          status_next = ght_pkg::ST_FULL;
        end else begin
          status_next = ght_pkg::ST_OK;
        end
      end
      ght_pkg::CMD_RESOLVE, ght_pkg::CMD_RELEASE: begin
        status_next = check_ok ? ght_pkg::ST_OK : ght_pkg::ST_REJECT;
      end
      default: begin
        status_next = ght_pkg::ST_OK;
      end
    endcase

    token_out_next  = alloc_go ? {kind_q, ght_pkg::TOK_GEN_W'(alloc_gen), slot_plus1} : '0;
    object_out_next = ((cmd_q == ght_pkg::CMD_RESOLVE) && check_ok) ?
                      ght_pkg::OBJ_PORT_W'(slot_rec.obj) : '0;

    slot_wr = '0;
    if (alloc_go) begin
      slot_wr.gen  = alloc_gen;
      slot_wr.kind = kind_q;
      slot_wr.obj  = obj_q;
    end else if (retire) begin
      slot_wr.retired = 1'b1;
      slot_wr.gen     = slot_rec.gen;
    end else begin
      slot_wr.gen = slot_rec.gen + GENERATION_BITS'(1);
    end
    bm_word_next = alloc_go ? (bm_word & ~exec_mask) : (bm_word | exec_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ght_pkg::S_IDLE;
      m_axis_tvalid  <= 1'b0;
      hw             <= '0;
      word_valid     <= '0;
      summary        <= '1;
      live_total     <= '0;
      rejected_total <= '0;
      retired_total  <= '0;
    end else begin
      unique case (state)
        ght_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ght_pkg::S_LOOK;
          end
        end
        ght_pkg::S_LOOK: begin
          state <= (cmd_q == ght_pkg::CMD_ALLOC) ? ght_pkg::S_PICK : ght_pkg::S_EXEC;
        end
        ght_pkg::S_PICK: begin
          state <= ght_pkg::S_EXEC;
        end
        ght_pkg::S_EXEC: begin
          if (exec_fire) begin
            state <= ght_pkg::S_IDLE;
          end
        end
        default: begin
          state <= ght_pkg::S_IDLE;
        end
      endcase

      if (exec_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (exec_fire) begin
        if (alloc_go) begin
          live_total <= live_total + ght_pkg::COUNT_W'(1);
          if ({1'b0, slot_addr_q} == hw) begin
            hw <= hw + (SLOT_IDX_W + 1)'(1);
          end
        end
        if (release_go) begin
          live_total <= live_total - ght_pkg::COUNT_W'(1);
          if (retire) begin
            retired_total <= retired_total + ght_pkg::COUNT_W'(1);
          end
        end
        if (reject) begin
          rejected_total <= rejected_total + ght_pkg::REJECT_W'(1);
        end
        if (alloc_go || (release_go && !retire)) begin
          word_valid[bm_addr_q] <= 1'b1;
          summary[bm_addr_q]    <= |bm_word_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q      <= s_axis_tdata[1:0];
      obj_q      <= s_axis_tdata[2 +: OBJ_W];
      kind_q     <= s_axis_tdata[40:34];
      token_q    <= s_axis_tdata[72:41];
      widx_q     <= free_word;
      any_free_q <= any_free;
    end
    if (exec_fire) begin
      status_q     <= status_next;
      token_out_q  <= token_out_next;
      object_out_q <= object_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_rd_en) begin
      slot_q      <= slot_mem[slot_rd_addr];
      slot_live_q <= ({1'b0, slot_rd_addr} < hw);
      slot_addr_q <= slot_rd_addr;
    end
    if (exec_fire && (alloc_go || release_go)) begin
      slot_mem[slot_addr_q] <= slot_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_rd_en) begin
      bm_q       <= bm_mem[bm_rd_addr];
      bm_valid_q <= word_valid[bm_rd_addr];
      bm_addr_q  <= bm_rd_addr;
    end
    if (exec_fire && (alloc_go || (release_go && !retire))) begin
      bm_mem[bm_addr_q] <= bm_word_next;
    end
  end

  assign m_axis_tdata = {1'b0, retired_total, rejected_total, live_total,
                         object_out_q, token_out_q, status_q};

endmodule
